// ===== src/wsd_pkg.sv =====
// Shared constants and types for the WebSocket frame deframer.
package wsd_pkg;

  localparam int LENGTH_BITS = 32;  // widest payload length accepted (16..32)
  localparam int ACCUM_BITS  = 32;  // extended length as assembled from the header

  localparam logic [7:0] RSV_MASK  = 8'h70;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT_BYTES16 = 4'd2;
  localparam logic [3:0] EXT_BYTES64 = 4'd8;
  localparam logic [3:0] EXT_UPPER   = 4'd4;  // above this count the byte is an upper byte

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RESERVED = 2'd1;
  localparam logic [1:0] ERR_TOO_WIDE = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
    logic [1:0] error_code;
  } res_t;

endpackage

// ===== src/wsd_if.sv =====
// Stream interfaces: raw input bytes and deframed result items.
interface wsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface wsd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_of_frame;
  logic       empty_frame;
  logic [1:0] error_code;

  modport source (output valid, output payload_byte, output last_of_frame,
                  output empty_frame, output error_code, input ready);
  modport sink (input valid, input payload_byte, input last_of_frame,
                input empty_frame, input error_code, output ready);
endinterface

// ===== src/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer.
//
//   channel | dir | payload                                             | transaction
//   din     | in  | data_byte[7:0]                                      | one raw byte
//   dout    | out | payload_byte[7:0] last_of_frame empty_frame err[1:0] | zero or one per byte
//
// One byte per cycle: the parser updates its state in the accepting cycle and the
// result lands in the output register, visible the next cycle.
// din.ready is low only while a held result is stalled by dout.ready.
// Synchronous active-high reset returns the parser to the first header byte and
// empties the output register.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  wsd_byte_if.sink din,
  wsd_res_if.source dout
);

  logic accept;
  logic in_ready;
  res_t res;

  assign din.ready = in_ready;
  assign accept    = din.valid && in_ready;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (din.data_byte),
    .res       (res)
  );

  wsd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .in_ready (in_ready),
    .dout     (dout)
  );

endmodule

// ===== src/wsd_parser.sv =====
// Header parser and payload counter: state update and result per byte.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  output res_t       res
);

  localparam logic [1:0] PH_HDR0    = 2'd0;
  localparam logic [1:0] PH_HDR1    = 2'd1;
  localparam logic [1:0] PH_EXT     = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]             phase, phase_next;
  logic [3:0]             ext_bytes_left, ext_bytes_left_next;
  logic [ACCUM_BITS-1:0]  length_accum, length_accum_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  logic                   upper_nonzero, upper_nonzero_next;
  logic [6:0]             len7;
  logic [3:0]             ext_dec;

  assign len7    = data_byte[6:0];
  assign ext_dec = ext_bytes_left - 4'd1;

  always_comb begin
    phase_next          = phase;
    ext_bytes_left_next = ext_bytes_left;
    length_accum_next   = length_accum;
    payload_left_next   = payload_left;
    upper_nonzero_next  = upper_nonzero;
    res                 = '0;
    case (phase)
      PH_HDR1: begin
        if (len7 < LEN_EXT16) begin
          if (len7 == 7'd0) begin
            phase_next        = PH_HDR0;
            res.valid         = 1'b1;
            res.last_of_frame = 1'b1;
            res.empty_frame   = 1'b1;
          end else begin
            payload_left_next = LENGTH_BITS'(len7);
            phase_next        = PH_PAYLOAD;
          end
        end else begin
          ext_bytes_left_next = (len7 == LEN_EXT16) ? EXT_BYTES16 : EXT_BYTES64;
          length_accum_next   = '0;
          upper_nonzero_next  = 1'b0;
          phase_next          = PH_EXT;
        end
      end
      PH_EXT: begin
        if (ext_bytes_left > EXT_UPPER) begin
          upper_nonzero_next = upper_nonzero | (data_byte != 8'd0);
        end else begin
          length_accum_next = {length_accum[ACCUM_BITS-9:0], data_byte};
        end
        ext_bytes_left_next = ext_dec;
        if (ext_dec == 4'd0) begin
          // final length byte: check width, then start payload or mark empty
          if (upper_nonzero_next || ((length_accum_next >> LENGTH_BITS) != '0)) begin
            upper_nonzero_next = 1'b0;
            phase_next         = PH_HDR0;
            res.valid          = 1'b1;
            res.last_of_frame  = 1'b1;
            res.error_code     = ERR_TOO_WIDE;
          end else if (length_accum_next == '0) begin
            phase_next        = PH_HDR0;
            res.valid         = 1'b1;
            res.last_of_frame = 1'b1;
            res.empty_frame   = 1'b1;
          end else begin
            payload_left_next = length_accum_next[LENGTH_BITS-1:0];
            phase_next        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = payload_left - LENGTH_BITS'(1);
        res.valid         = 1'b1;
        res.payload_byte  = data_byte;
        if (payload_left_next == '0) begin
          res.last_of_frame = 1'b1;
          phase_next        = PH_HDR0;
        end
      end
      default: begin
        if ((data_byte & RSV_MASK) != 8'd0) begin
          res.valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.error_code    = ERR_RESERVED;
        end else begin
          phase_next = PH_HDR1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HDR0;
      ext_bytes_left <= '0;
      upper_nonzero  <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      ext_bytes_left <= ext_bytes_left_next;
      upper_nonzero  <= upper_nonzero_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      length_accum <= length_accum_next;
      payload_left <= payload_left_next;
    end
  end

endmodule

// ===== src/wsd_out_stage.sv =====
// Result register: holds one result until the consumer takes it.
module wsd_out_stage
  import wsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  res_t             res,
  output logic             in_ready,
  wsd_res_if.source        dout
);

  logic valid;
  res_t held;

  // take a new byte whenever the slot is empty or drains this cycle
  assign in_ready = !valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= res.valid;
    end else if (dout.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      held <= res;
    end
  end

  assign dout.valid         = valid;
  assign dout.payload_byte  = held.payload_byte;
  assign dout.last_of_frame = held.last_of_frame;
  assign dout.empty_frame   = held.empty_frame;
  assign dout.error_code    = held.error_code;

endmodule

// ===== src/wsd_checker.sv =====
// Port-level assertions for the deframer, bound to the top level.
module wsd_checker
  import wsd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] payload_byte,
  input logic       last_of_frame,
  input logic       empty_frame,
  input logic [1:0] error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_NONE) |->
      last_of_frame && !empty_frame && (payload_byte == 8'd0))
    else $error("malformed error result");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_frame |->
      last_of_frame && (error_code == ERR_NONE) && (payload_byte == 8'd0))
    else $error("malformed empty marker");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without an accepted byte");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (din.valid),
  .in_ready      (din.ready),
  .out_valid     (dout.valid),
  .out_ready     (dout.ready),
  .payload_byte  (dout.payload_byte),
  .last_of_frame (dout.last_of_frame),
  .empty_frame   (dout.empty_frame),
  .error_code    (dout.error_code)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the WebSocket frame deframer: directed header cases, random frames.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 880;
  localparam int unsigned STAGE_LEN    = 180;
  localparam int unsigned STALL_BURST  = 40;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned SHORT_MAX    = 125;
  localparam realtime     RUN_LIMIT    = 400us;

  typedef enum logic [1:0] {PH_FIRST, PH_SECOND, PH_EXTLEN, PH_BODY} frame_phase_e;
  typedef enum int {FORM_7, FORM_16, FORM_64} len_form_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic       empty_frame;
    logic [1:0] error_code;
  } deframed_t;

  typedef struct packed {
    logic [7:0] data;
    bit         typed;
    bit         has;
    deframed_t  res;
  } stim_row_t;

  localparam deframed_t NO_RES    = '0;
  localparam deframed_t RES_RSV   = '{8'h00, 1'b1, 1'b0, ERR_RESERVED};
  localparam deframed_t RES_WIDE  = '{8'h00, 1'b1, 1'b0, ERR_TOO_WIDE};
  localparam deframed_t RES_EMPTY = '{8'h00, 1'b1, 1'b1, ERR_NONE};
  localparam deframed_t RES_FF    = '{8'hFF, 1'b1, 1'b0, ERR_NONE};

  // Rows left untyped are checked against the predictor.
  localparam int unsigned DIRECTED_ROWS = 25;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'hF0, 1'b1, 1'b1, RES_RSV},    // all reserved bits set
    '{8'h10, 1'b1, 1'b1, RES_RSV},    // lowest reserved bit only
    '{8'h0F, 1'b1, 1'b0, NO_RES},
    '{8'h80, 1'b1, 1'b1, RES_EMPTY},  // mask bit set, zero length
    '{8'h82, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, RES_FF},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hA5, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'hFE, 1'b0, 1'b0, NO_RES},     // 16-bit extended length
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, RES_EMPTY},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h7F, 1'b0, 1'b0, NO_RES},     // 64-bit extended length
    '{8'h80, 1'b0, 1'b0, NO_RES},     // top bit of the upper word
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, RES_WIDE}
  };

  logic clk;
  logic rst;

  wsd_byte_if din ();
  wsd_res_if  dout ();

  websocket_frame_deframer u_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Deframer state as predicted
  frame_phase_e ph;
  logic [3:0]   ext_left;
  logic [31:0]  len_acc;
  logic [31:0]  body_left;
  logic         upper_seen;

  deframed_t    pending_out_q [$];
  int unsigned  mismatch_cnt;
  int unsigned  bytes_sent;
  int unsigned  gap_pct;
  int unsigned  stall_pct;
  bit           stall_burst_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic bit deframe_byte(input logic [7:0] b, output deframed_t r);
    bit          got;
    bit          have_len;
    logic [31:0] len;
    got      = 1'b0;
    have_len = 1'b0;
    len      = '0;
    r        = '0;
    case (ph)
      PH_SECOND: begin
        if (b[6:0] < LEN_EXT16) begin
          have_len = 1'b1;
          len      = 32'(b[6:0]);
        end else begin
          ext_left   = (b[6:0] == LEN_EXT16) ? EXT_BYTES16 : EXT_BYTES64;
          len_acc    = '0;
          upper_seen = 1'b0;
          ph         = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        // upper word of a 64-bit length only needs to be zero
        if (ext_left > EXT_UPPER) begin
          if (b != 8'h00) upper_seen = 1'b1;
        end else
          len_acc = {len_acc[23:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) begin
          if (upper_seen || (64'(len_acc) >> LENGTH_BITS) != 0) begin
            upper_seen = 1'b0;
            ph         = PH_FIRST;
            r          = '{8'h00, 1'b1, 1'b0, ERR_TOO_WIDE};
            got        = 1'b1;
          end else begin
            have_len = 1'b1;
            len      = len_acc;
          end
        end
      end
      PH_BODY: begin
        body_left = body_left - 32'd1;
        if (body_left == 0) ph = PH_FIRST;
        r   = '{b, body_left == 0, 1'b0, ERR_NONE};
        got = 1'b1;
      end
      default: begin
        if ((b & RSV_MASK) != 8'h00) begin
          ph  = PH_FIRST;
          r   = '{8'h00, 1'b1, 1'b0, ERR_RESERVED};
          got = 1'b1;
        end else
          ph = PH_SECOND;
      end
    endcase
    if (have_len) begin
      if (len == 0) begin
        ph  = PH_FIRST;
        r   = '{8'h00, 1'b1, 1'b1, ERR_NONE};
        got = 1'b1;
      end else begin
        body_left = len;
        ph        = PH_BODY;
      end
    end
    return got;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_result(input deframed_t got);
    deframed_t want;
    if (pending_out_q.size() == 0) begin
      report_mismatch($sformatf("result %03h with nothing expected", got));
      return;
    end
    want = pending_out_q.pop_front();
    if (got.payload_byte !== want.payload_byte)
      report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                got.payload_byte, want.payload_byte));
    if (got.last_of_frame !== want.last_of_frame)
      report_mismatch($sformatf("last_of_frame %b, expected %b",
                                got.last_of_frame, want.last_of_frame));
    if (got.empty_frame !== want.empty_frame)
      report_mismatch($sformatf("empty_frame %b, expected %b",
                                got.empty_frame, want.empty_frame));
    if (got.error_code !== want.error_code)
      report_mismatch($sformatf("error_code %0d, expected %0d",
                                got.error_code, want.error_code));
  endtask

  // Offer one byte and, once the transaction completes, predict what it causes.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input deframed_t typed_res = '0);
    deframed_t res;
    bit        has;
    while ($urandom_range(99) < gap_pct) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid     <= 1'b1;
    din.data_byte <= b;
    do @(posedge clk); while (!din.ready);
    has = deframe_byte(b, res);
    if (typed) begin
      has = typed_has;
      res = typed_res;
    end
    if (has) pending_out_q.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned k;
    len_form_e   form;
    logic [7:0]  hdr;
    logic [31:0] len;
    logic [31:0] upper;
    pick = $urandom_range(99);
    hdr  = 8'($urandom);
    if (pick < 12) begin
      // broken header byte
      hdr[6:4] = 3'($urandom_range(1, 7));
      send_byte(hdr);
    end else if (pick < 20) begin
      // 64-bit length with a nonzero upper word
      k     = $urandom_range(3);
      upper = $urandom_range(1) ? 32'($urandom) : 32'h0;
      upper[8*k +: 8] = 8'($urandom_range(1, 255));
      hdr[6:4] = 3'b000;
      send_byte(hdr);
      send_byte({1'($urandom), LEN_EXT64});
      for (int i = 3; i >= 0; i--) send_byte(upper[8*i +: 8]);
      repeat (4) send_byte(8'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 8)       len = 0;
      else if (pick < 85) len = $urandom_range(1, 12);
      else if (pick < 95) len = $urandom_range(3) == 0 ? SHORT_MAX : $urandom_range(13, 124);
      else                len = $urandom_range(126, 300);
      form = len_form_e'($urandom_range(2));
      if (len > SHORT_MAX && form == FORM_7) form = FORM_16;
      hdr[6:4] = 3'b000;
      send_byte(hdr);
      case (form)
        FORM_7: send_byte({1'($urandom), len[6:0]});
        FORM_16: begin
          send_byte({1'($urandom), LEN_EXT16});
          send_byte(len[15:8]);
          send_byte(len[7:0]);
        end
        default: begin
          send_byte({1'($urandom), LEN_EXT64});
          repeat (4) send_byte(8'h00);
          for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
        end
      endcase
      repeat (len) send_byte(8'($urandom));
    end
  endtask

  // Result sink: random stalls plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_burst_req) begin
        stall_left      = STALL_BURST;
        stall_burst_req = 1'b0;
      end
      if (stall_left != 0) begin
        stall_left--;
        dout.ready <= 1'b0;
      end else
        dout.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready)
      check_result({dout.payload_byte, dout.last_of_frame, dout.empty_frame, dout.error_code});
  end

  initial begin
    rst             <= 1'b1;
    din.valid       <= 1'b0;
    din.data_byte   <= 8'h00;
    gap_pct         = 0;
    stall_pct       = 0;
    stall_burst_req = 1'b0;
    mismatch_cnt    = 0;
    bytes_sent      = 0;
    ph              = PH_FIRST;
    ext_left        = '0;
    len_acc         = '0;
    body_left       = '0;
    upper_seen      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_byte(DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].has, DIRECTED[i].res);

    // fill the block while the sink holds off
    stall_burst_req = 1'b1;
    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
      case ((bytes_sent / STAGE_LEN) % 5)
        1: begin
          gap_pct   = 81;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 81;
        end
        3: begin
          gap_pct   = 16;
          stall_pct = 16;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase
      send_random_frame();
    end
    din.valid <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;

    while (pending_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
src/wsd_pkg.sv
src/wsd_if.sv
src/wsd_parser.sv
src/wsd_out_stage.sv
src/websocket_frame_deframer.sv
src/wsd_checker.sv
tb/tb_top.sv
